// ===== hw/rtl/packet_length_ring_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet length ring FIFO
// Shared clocking and reset qualification for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PACKET_LENGTH_RING_FIFO_ASSERT_SVH
`define PACKET_LENGTH_RING_FIFO_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PLRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true outside reset
`define PLRF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/plrf_pkg.sv =====
// ----------------------------------------------------------------------------
// plrf_pkg
// Shared types and constants of the packet length ring FIFO.
// ----------------------------------------------------------------------------
package plrf_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 7;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 11;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = 3;
	localparam int OUT_PTR_W = 2;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_PACKET = 3'd1;
	localparam logic [STATUS_W-1:0] STS_TOO_SMALL = 3'd2;
	localparam logic [STATUS_W-1:0] STS_STORE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STS_TOO_LONG  = 3'd4;
	localparam logic [STATUS_W-1:0] STS_RING_FULL = 3'd5;

	typedef struct packed {
		mode_t             kind;
		logic [BYTE_W-1:0] data;
		logic              eop;
		logic              rec;
		logic [LEN_W-1:0]  cap;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                last;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    len;
	} res_t;

endpackage

// ===== hw/rtl/plrf_front.sv =====
// ----------------------------------------------------------------------------
// plrf_front
// Accepts input beats, drops unused modes and queues commands for the back end.
// ----------------------------------------------------------------------------
module plrf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  mode,
	input  logic [plrf_pkg::BYTE_W-1:0] data_byte,
	input  logic                        end_of_packet,
	input  logic                        record_length,
	input  logic [plrf_pkg::LEN_W-1:0]  max_length,
	output logic                        cmd_valid,
	output plrf_pkg::cmd_t              cmd,
	input  logic                        cmd_take
);

	localparam int CQ_DEPTH = 2;

	plrf_pkg::cmd_t cq_q [CQ_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           accept;
	logic           keep;
	plrf_pkg::cmd_t new_cmd;

	assign full   = (cnt_q == 2'(CQ_DEPTH));
	assign accept = push && !full;

	always_comb begin
		keep = 1'b0;
		unique case (mode)
			plrf_pkg::MODE_PUSH, plrf_pkg::MODE_POP, plrf_pkg::MODE_CLEAR: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign new_cmd.kind = plrf_pkg::mode_t'(mode);
	assign new_cmd.data = data_byte;
	assign new_cmd.eop  = end_of_packet;
	assign new_cmd.rec  = record_length;
	assign new_cmd.cap  = max_length;

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			cq_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(accept && keep) - 2'(cmd_take);
		end
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cq_q[rd_ptr_q];

endmodule

// ===== hw/rtl/plrf_result_fifo.sv =====
// ----------------------------------------------------------------------------
// plrf_result_fifo
// Small result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module plrf_result_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr,
	input  plrf_pkg::res_t                 wdata,
	output logic [plrf_pkg::OUT_CNT_W-1:0] count,
	output logic                           empty,
	input  logic                           pop,
	output plrf_pkg::res_t                 head
);

	`include "packet_length_ring_fifo_assert.svh"

	plrf_pkg::res_t                 mem_q [plrf_pkg::OUT_DEPTH];
	logic [plrf_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [plrf_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [plrf_pkg::OUT_CNT_W-1:0] cnt_q;
	logic                           rd;

	assign empty = (cnt_q == '0);
	assign rd    = pop && !empty;
	assign count = cnt_q;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + plrf_pkg::OUT_CNT_W'(wr) - plrf_pkg::OUT_CNT_W'(rd);
		end
	end

	`PLRF_NEVER(a_no_overflow, wr && !rd && (cnt_q == plrf_pkg::OUT_CNT_W'(plrf_pkg::OUT_DEPTH)), "result queue overflow")
	`PLRF_ASSERT(a_cnt_up, wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1, "result count did not rise")
	`PLRF_ASSERT(a_cnt_down, rd && !wr |=> cnt_q == $past(cnt_q) - 1'b1, "result count did not fall")

endmodule

// ===== hw/rtl/plrf_back.sv =====
// ----------------------------------------------------------------------------
// plrf_back
// Executes queued commands against the byte ring and the length record ring.
// ----------------------------------------------------------------------------
module plrf_back #(
	parameter int STORE_DEPTH  = 1024,
	parameter int MAX_PACKET   = 64,
	parameter int RECORD_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [plrf_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           cmd_valid,
	input  plrf_pkg::cmd_t                 cmd,
	output logic                           cmd_take,
	input  logic [plrf_pkg::OUT_CNT_W-1:0] res_count,
	output logic                           res_wr,
	output plrf_pkg::res_t                 res
);

	`include "packet_length_ring_fifo_assert.svh"

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = (AW + 1 > plrf_pkg::CFG_W) ? AW + 1 : plrf_pkg::CFG_W;
	localparam int RW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int LW = plrf_pkg::LEN_W;
	localparam int SW = plrf_pkg::STATUS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REC,
		ST_STREAM
	} state_t;

	state_t                     state_q;
	logic [plrf_pkg::CFG_W-1:0] buf_size_q;
	logic [AW-1:0]              wr_idx_q;
	logic [AW-1:0]              rd_idx_q;
	logic [AW:0]                stored_q;
	logic [LW-1:0]              cur_q;
	logic [RW-1:0]              lwi_q;
	logic [RW-1:0]              lri_q;
	logic [RW:0]                pend_q;
	logic [LW-1:0]              cap_q;
	logic [LW-1:0]              plen_q;
	logic [LW-1:0]              remain_q;

	logic [plrf_pkg::BYTE_W-1:0] byte_mem [STORE_DEPTH];
	logic [LW-1:0]               rec_mem [RECORD_DEPTH];
	logic [plrf_pkg::BYTE_W-1:0] byte_rd_q;
	logic [LW-1:0]               rec_rd_q;

	logic          res_valid_s1;
	logic          is_byte_s1;
	logic          last_s1;
	logic [SW-1:0] status_s1;
	logic [LW-1:0] len_s1;

	logic [CW-1:0] size;
	logic [CW-1:0] buf_ext;
	logic          room;
	logic          go;
	logic          store_full;
	logic          too_long;
	logic          push_ok;
	logic          ring_full;
	logic [LW-1:0] cur_inc;
	logic          byte_we;
	logic          rec_we;

	function automatic logic [AW-1:0] next_byte(input logic [AW-1:0] idx,
	                                             input logic [CW-1:0] sz);
		logic [CW-1:0] n;
		n = CW'(idx) + 1'b1;
		return (n >= sz) ? '0 : AW'(n);
	endfunction

	function automatic logic [RW-1:0] next_rec(input logic [RW-1:0] idx);
		return (idx == RW'(RECORD_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// clamp the configured ring size into 1..STORE_DEPTH
	always_comb begin
		buf_ext = CW'(buf_size_q);
		if (buf_ext == '0) begin
			size = CW'(1);
		end else if (buf_ext > CW'(STORE_DEPTH)) begin
			size = CW'(STORE_DEPTH);
		end else begin
			size = buf_ext;
		end
	end

	// issue a result only when the queue can hold it and the one in flight
	assign room = ({1'b0, res_count} + 4'(res_valid_s1)) < 4'(plrf_pkg::OUT_DEPTH);
	assign go   = (state_q == ST_IDLE) && cmd_valid && room;
	assign cmd_take = go;

	assign store_full = (CW'(stored_q) >= size);
	assign too_long   = (cur_q >= LW'(MAX_PACKET));
	assign push_ok    = !store_full && !too_long;
	assign ring_full  = (pend_q >= (RW + 1)'(RECORD_DEPTH));
	assign cur_inc    = cur_q + 1'b1;
	assign byte_we    = go && (cmd.kind == plrf_pkg::MODE_PUSH) && push_ok;
	assign rec_we     = byte_we && cmd.eop && cmd.rec && !ring_full;

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[wr_idx_q] <= cmd.data;
		end
		byte_rd_q <= byte_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[lwi_q] <= cur_inc;
		end
		rec_rd_q <= rec_mem[lri_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			buf_size_q   <= plrf_pkg::CFG_W'(1024);
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			stored_q     <= '0;
			cur_q        <= '0;
			lwi_q        <= '0;
			lri_q        <= '0;
			pend_q       <= '0;
			cap_q        <= '0;
			plen_q       <= '0;
			remain_q     <= '0;
			res_valid_s1 <= 1'b0;
			is_byte_s1   <= 1'b0;
			last_s1      <= 1'b0;
			status_s1    <= plrf_pkg::STS_OK;
			len_s1       <= '0;
		end else begin
			res_valid_s1 <= 1'b0;
			if (cfg_we) begin
				buf_size_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						is_byte_s1 <= 1'b0;
						last_s1    <= 1'b1;
						status_s1  <= plrf_pkg::STS_OK;
						len_s1     <= '0;
						unique case (cmd.kind)
							plrf_pkg::MODE_PUSH: begin
								res_valid_s1 <= 1'b1;
								if (!push_ok) begin
									status_s1 <= store_full ? plrf_pkg::STS_STORE_FULL
									                        : plrf_pkg::STS_TOO_LONG;
									len_s1    <= cur_q;
									if (cmd.eop) begin
										cur_q <= '0;
									end
								end else begin
									wr_idx_q <= next_byte(wr_idx_q, size);
									stored_q <= stored_q + 1'b1;
									len_s1   <= cur_inc;
									cur_q    <= cmd.eop ? '0 : cur_inc;
									if (cmd.eop && cmd.rec) begin
										if (ring_full) begin
											status_s1 <= plrf_pkg::STS_RING_FULL;
										end else begin
											lwi_q  <= next_rec(lwi_q);
											pend_q <= pend_q + 1'b1;
										end
									end
								end
							end
							plrf_pkg::MODE_POP: begin
								if (pend_q == '0) begin
									res_valid_s1 <= 1'b1;
									status_s1    <= plrf_pkg::STS_NO_PACKET;
								end else begin
									// record read lands next cycle
									cap_q   <= cmd.cap;
									state_q <= ST_REC;
								end
							end
							plrf_pkg::MODE_CLEAR: begin
								res_valid_s1 <= 1'b1;
								wr_idx_q     <= '0;
								rd_idx_q     <= '0;
								stored_q     <= '0;
								cur_q        <= '0;
							end
							default: begin
								res_valid_s1 <= 1'b0;
							end
						endcase
					end
				end
				ST_REC: begin
					if (room) begin
						is_byte_s1 <= 1'b0;
						last_s1    <= 1'b1;
						if (cap_q < rec_rd_q) begin
							// refuse, keep the record
							res_valid_s1 <= 1'b1;
							status_s1    <= plrf_pkg::STS_TOO_SMALL;
							len_s1       <= rec_rd_q;
							state_q      <= ST_IDLE;
						end else begin
							lri_q  <= next_rec(lri_q);
							pend_q <= pend_q - 1'b1;
							if (rec_rd_q == '0) begin
								res_valid_s1 <= 1'b1;
								status_s1    <= plrf_pkg::STS_OK;
								len_s1       <= '0;
								state_q      <= ST_IDLE;
							end else begin
								remain_q <= rec_rd_q;
								plen_q   <= rec_rd_q;
								state_q  <= ST_STREAM;
							end
						end
					end
				end
				ST_STREAM: begin
					if (room) begin
						res_valid_s1 <= 1'b1;
						is_byte_s1   <= 1'b1;
						last_s1      <= (remain_q == LW'(1));
						status_s1    <= plrf_pkg::STS_OK;
						len_s1       <= plen_q;
						rd_idx_q     <= next_byte(rd_idx_q, size);
						if (stored_q != '0) begin
							stored_q <= stored_q - 1'b1;
						end
						remain_q <= remain_q - 1'b1;
						if (remain_q == LW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_wr       = res_valid_s1;
	assign res.out_byte = is_byte_s1 ? byte_rd_q : '0;
	assign res.last     = last_s1;
	assign res.status   = status_s1;
	assign res.len      = len_s1;

	`PLRF_NEVER(a_credit, res_valid_s1 && (res_count == plrf_pkg::OUT_CNT_W'(plrf_pkg::OUT_DEPTH)), "result issued without room")
	`PLRF_NEVER(a_pend_bound, pend_q > (RW + 1)'(RECORD_DEPTH), "record count beyond ring depth")
	`PLRF_NEVER(a_stream_len, (state_q == ST_STREAM) && (remain_q == '0), "streaming with no bytes left")

endmodule

// ===== hw/rtl/packet_length_ring_fifo.sv =====
// Results: a push, clear or empty-ring pop beat gives one result on the result ports.
// Push and clear beats sustain one beat per cycle through the command queue while the
// result queue has room. A pop first reads its length record from the record ring,
// then gives one byte result per cycle, read from the registered byte store read port,
// while the result queue has room.
// Reset: arst_n clears all pointers, counts and queues; buffer_size returns to 1024.
// ----------------------------------------------------------------------------
// packet_length_ring_fifo
// Byte ring store with a ring of packet length records, queue ports both sides.
// ----------------------------------------------------------------------------
module packet_length_ring_fifo #(
	parameter int STORE_DEPTH  = 1024,
	parameter int MAX_PACKET   = 64,
	parameter int RECORD_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [plrf_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          end_of_packet,
	input  logic                          record_length,
	input  logic [plrf_pkg::LEN_W-1:0]    max_length,
	output logic                          empty,
	input  logic                          pop,
	output logic [plrf_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last,
	output logic [plrf_pkg::STATUS_W-1:0] status,
	output logic [plrf_pkg::LEN_W-1:0]    packet_length,
	input  logic                          cfg_we,
	input  logic [plrf_pkg::CFG_W-1:0]    cfg_wdata
);

	logic                           cmd_valid;
	plrf_pkg::cmd_t                 cmd;
	logic                           cmd_take;
	logic [plrf_pkg::OUT_CNT_W-1:0] res_count;
	logic                           res_wr;
	plrf_pkg::res_t                 res;
	plrf_pkg::res_t                 head;

	plrf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.record_length (record_length),
		.max_length    (max_length),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_take      (cmd_take)
	);

	plrf_back #(
		.STORE_DEPTH  (STORE_DEPTH),
		.MAX_PACKET   (MAX_PACKET),
		.RECORD_DEPTH (RECORD_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_count (res_count),
		.res_wr    (res_wr),
		.res       (res)
	);

	plrf_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res),
		.count  (res_count),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign out_byte      = head.out_byte;
	assign last          = head.last;
	assign status        = head.status;
	assign packet_length = head.len;

endmodule
